// ===== rtl/core/sqg_pkg.sv =====
// Package for the single-qubit gate unit: beat types, gate codes and the
// quarter-wave sine table built at elaboration. No dependencies.
`default_nettype none

package sqg_pkg;

  localparam int SINE_TABLE_DEPTH = 256;
  localparam int SINE_IDX_W       = $clog2(SINE_TABLE_DEPTH + 1);

  // Coefficients cover [-1.0, +1.0] in units of 2^-15, so they need 17 bits.
  localparam int COEF_W = 17;
  localparam int AMP_W  = 16;
  // Four 17x16 products summed, plus the rounding offset.
  localparam int ACC_W  = 35;

  localparam logic signed [COEF_W-1:0] ONE_Q15       = COEF_W'(32768);
  localparam logic signed [COEF_W-1:0] INV_SQRT2_Q15 = COEF_W'(23170);
  localparam longint unsigned          HALF_PI_Q30   = 64'd1686629713;

  typedef enum logic [3:0] {
    GATE_H    = 4'd0,
    GATE_X    = 4'd1,
    GATE_Y    = 4'd2,
    GATE_Z    = 4'd3,
    GATE_I    = 4'd4,
    GATE_S    = 4'd5,
    GATE_T    = 4'd6,
    GATE_SDAG = 4'd7,
    GATE_TDAG = 4'd8,
    GATE_RX   = 4'd9,
    GATE_RY   = 4'd10,
    GATE_RZ   = 4'd11
  } gate_kind_t;

  typedef struct packed {
    logic [3:0]              kind;
    logic [15:0]             angle;
    logic signed [AMP_W-1:0] amp0_re;
    logic signed [AMP_W-1:0] amp0_im;
    logic signed [AMP_W-1:0] amp1_re;
    logic signed [AMP_W-1:0] amp1_im;
  } in_item_t;

  typedef struct packed {
    logic signed [AMP_W-1:0] new0_re;
    logic signed [AMP_W-1:0] new0_im;
    logic signed [AMP_W-1:0] new1_re;
    logic signed [AMP_W-1:0] new1_im;
    logic                    clipped;
  } out_item_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] re;
    logic signed [COEF_W-1:0] im;
  } coef_t;

  typedef logic [SINE_TABLE_DEPTH:0][15:0] sine_lut_t;

  // Taylor series through x^15 in Q30 with truncated terms, rounded to Q15.
  function automatic logic [15:0] sine_entry(int unsigned k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned sum;
    longint unsigned r;
    x    = (64'(k) * HALF_PI_Q30) / 64'(SINE_TABLE_DEPTH);
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    for (int unsigned n = 1; n <= 7; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n[0]) begin
        sum = (sum >= term) ? sum - term : 64'd0;
      end else begin
        sum = sum + term;
      end
    end
    r = (sum + 64'd16384) >> 15;
    if (r > 64'd32768) begin
      r = 64'd32768;
    end
    return 16'(r);
  endfunction

  function automatic sine_lut_t build_sine_lut();
    sine_lut_t lut;
    for (int unsigned k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      lut[k] = sine_entry(k);
    end
    return lut;
  endfunction

  localparam sine_lut_t SINE_LUT = build_sine_lut();

endpackage

`default_nettype wire

// ===== rtl/core/single_qubit_gate_apply_unit.sv =====
// Top level of the single-qubit gate unit: input register, gate datapath and
// result register with valid/ready flow control. Uses sqg_pkg, sqg_gate_math.
//
// Each input beat carries a gate code, a rotation angle and a two-amplitude
// Q1.15 state; the unit returns the state multiplied by the gate matrix,
// rounded half up and saturated to Q1.15, with a flag when any component
// clipped. One beat is accepted per clock unless the output stalls. A result
// is presented on the output once the result register captures it: the input
// register feeds the gate datapath, whose output the result register captures
// when empty or being drained. While a result waits to be taken the input
// register can hold one more beat; after that the input stalls until the sink
// takes the result. Sustained throughput is one beat per cycle whenever the
// sink is ready.
`default_nettype none

module single_qubit_gate_apply_unit
  import sqg_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  logic      s1_valid_r, s1_valid_nxt;
  in_item_t  s1_item_r;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r;
  out_item_t result;
  logic      out_load;
  logic      s1_load;

  sqg_gate_math u_math (
    .item   (s1_item_r),
    .result (result)
  );

  // The result register takes a new beat when empty or being drained.
  assign out_load = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || out_load;
  assign s1_load  = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = s1_valid_r;
      s1_valid_nxt  = 1'b0;
    end
    if (s1_load) begin
      s1_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_item_r <= in_data;
    end
    if (out_load && s1_valid_r) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule

`default_nettype wire

// ===== rtl/core/sqg_gate_math.sv =====
// Combinational gate datapath: half-angle sin/cos lookup, gate matrix,
// complex matrix-vector product, rounding and saturation. Uses sqg_pkg.
`default_nettype none

module sqg_gate_math
  import sqg_pkg::*;
(
  input  wire in_item_t item,
  output out_item_t     result
);

  localparam int PROD_W = 15 + SINE_IDX_W;
  localparam logic signed [ACC_W-1:0] Q_MAX = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] Q_MIN = -ACC_W'(32768);
  localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(16384);

  typedef struct packed {
    logic                    clip;
    logic signed [AMP_W-1:0] value;
  } sat_t;

  function automatic logic signed [ACC_W-1:0] row_sum(
    coef_t ma, coef_t mb,
    logic signed [AMP_W-1:0] a_re, logic signed [AMP_W-1:0] a_im,
    logic signed [AMP_W-1:0] b_re, logic signed [AMP_W-1:0] b_im,
    logic imag
  );
    logic signed [ACC_W-1:0] s;
    if (!imag) begin
      s = ACC_W'(ma.re) * ACC_W'(a_re) - ACC_W'(ma.im) * ACC_W'(a_im)
        + ACC_W'(mb.re) * ACC_W'(b_re) - ACC_W'(mb.im) * ACC_W'(b_im);
    end else begin
      s = ACC_W'(ma.re) * ACC_W'(a_im) + ACC_W'(ma.im) * ACC_W'(a_re)
        + ACC_W'(mb.re) * ACC_W'(b_im) + ACC_W'(mb.im) * ACC_W'(b_re);
    end
    return s;
  endfunction

  // Round half up to Q15 (the arithmetic shift floors), then clamp.
  function automatic sat_t round_sat(logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] q;
    sat_t r;
    q = (v + HALF_LSB) >>> 15;
    r.clip = 1'b0;
    if (q > Q_MAX) begin
      r.clip  = 1'b1;
      r.value = AMP_W'(Q_MAX);
    end else if (q < Q_MIN) begin
      r.clip  = 1'b1;
      r.value = AMP_W'(Q_MIN);
    end else begin
      r.value = AMP_W'(q);
    end
    return r;
  endfunction

  logic [PROD_W-1:0]     off_scaled;
  logic [SINE_IDX_W-1:0] idx;
  logic [SINE_IDX_W-1:0] idx_mirror;
  logic signed [COEF_W-1:0] t_idx;
  logic signed [COEF_W-1:0] t_mirror;
  logic signed [COEF_W-1:0] sin_h;
  logic signed [COEF_W-1:0] cos_h;
  coef_t m00, m01, m10, m11;
  sat_t  r0, i0, r1, i1;

  // The angle field already counts half-angle steps of 2*pi/131072.
  assign off_scaled = PROD_W'(item.angle[14:0]) * PROD_W'(SINE_TABLE_DEPTH);
  assign idx        = off_scaled[PROD_W-1:15];
  assign idx_mirror = SINE_IDX_W'(SINE_TABLE_DEPTH) - idx;
  assign t_idx      = COEF_W'(SINE_LUT[idx]);
  assign t_mirror   = COEF_W'(SINE_LUT[idx_mirror]);

  always_comb begin
    if (!item.angle[15]) begin
      sin_h = t_idx;
      cos_h = t_mirror;
    end else begin
      sin_h = t_mirror;
      cos_h = -t_idx;
    end
  end

  always_comb begin
    m00 = '{re: ONE_Q15, im: '0};
    m01 = '0;
    m10 = '0;
    m11 = '{re: ONE_Q15, im: '0};
    case (gate_kind_t'(item.kind))
      GATE_H: begin
        m00.re = INV_SQRT2_Q15;
        m01.re = INV_SQRT2_Q15;
        m10.re = INV_SQRT2_Q15;
        m11.re = -INV_SQRT2_Q15;
      end
      GATE_X: begin
        m00    = '0;
        m11    = '0;
        m01.re = ONE_Q15;
        m10.re = ONE_Q15;
      end
      GATE_Y: begin
        m00    = '0;
        m11    = '0;
        m01.im = -ONE_Q15;
        m10.im = ONE_Q15;
      end
      GATE_Z: begin
        m11.re = -ONE_Q15;
      end
      GATE_I: begin
      end
      GATE_S: begin
        m11.re = '0;
        m11.im = ONE_Q15;
      end
      GATE_T: begin
        m11.re = INV_SQRT2_Q15;
        m11.im = INV_SQRT2_Q15;
      end
      GATE_SDAG: begin
        m11.re = '0;
        m11.im = -ONE_Q15;
      end
      GATE_TDAG: begin
        m11.re = INV_SQRT2_Q15;
        m11.im = -INV_SQRT2_Q15;
      end
      GATE_RX: begin
        m00.re = cos_h;
        m11.re = cos_h;
        m01.im = -sin_h;
        m10.im = -sin_h;
      end
      GATE_RY: begin
        m00.re = cos_h;
        m11.re = cos_h;
        m01.re = -sin_h;
        m10.re = sin_h;
      end
      GATE_RZ: begin
        m00.re = cos_h;
        m00.im = -sin_h;
        m11.re = cos_h;
        m11.im = sin_h;
      end
      // Unassigned gate codes behave as the identity.
      default: begin
      end
    endcase
  end

  assign r0 = round_sat(row_sum(m00, m01, item.amp0_re, item.amp0_im,
                                item.amp1_re, item.amp1_im, 1'b0));
  assign i0 = round_sat(row_sum(m00, m01, item.amp0_re, item.amp0_im,
                                item.amp1_re, item.amp1_im, 1'b1));
  assign r1 = round_sat(row_sum(m10, m11, item.amp0_re, item.amp0_im,
                                item.amp1_re, item.amp1_im, 1'b0));
  assign i1 = round_sat(row_sum(m10, m11, item.amp0_re, item.amp0_im,
                                item.amp1_re, item.amp1_im, 1'b1));

  assign result.new0_re = r0.value;
  assign result.new0_im = i0.value;
  assign result.new1_re = r1.value;
  assign result.new1_im = i1.value;
  assign result.clipped = r0.clip | i0.clip | r1.clip | i1.clip;

endmodule

`default_nettype wire

// ===== sim/single_qubit_gate_apply_unit_test.sv =====
// Testbench for single_qubit_gate_apply_unit: random and directed gate beats,
// checked against an in-bench fixed-point gate predictor.
// Depends on sqg_pkg and the RTL of the unit only.
`timescale 1ns / 100ps

module single_qubit_gate_apply_unit_test
  import sqg_pkg::*;
();

  localparam int UNIT_Q15    = 32768;
  localparam int HALF_ROOT2  = 23170;
  localparam int CYCLE_LIMIT = 400000;
  localparam int CALM_TAIL   = 60;

  typedef struct {
    in_item_t beat;
    bit       drain;
  } queued_beat_t;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  queued_beat_t gate_beats[$];
  out_item_t    amps_due[$];
  bit           in_taken = 1'b0;
  int           send_gap = 0;
  int           sink_stall = 0;
  int           cycle_count = 0;
  int           mismatch_count = 0;

  single_qubit_gate_apply_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Taylor series of the quarter-wave sine in Q30, every term truncated.
  function automatic int quarter_sine(int unsigned k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned sum;
    longint unsigned r;
    x = k;
    x = (x * HALF_PI_Q30) / SINE_TABLE_DEPTH;
    x2 = (x * x) >> 30;
    term = x;
    sum = x;
    for (int unsigned n = 1; n <= 7; n++) begin
      term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        sum = (sum >= term) ? sum - term : 0;
      end else begin
        sum = sum + term;
      end
    end
    r = (sum + 16384) >> 15;
    if (r > UNIT_Q15) begin
      r = UNIT_Q15;
    end
    return int'(r);
  endfunction

  // Round half up from 2^-30 to 2^-15 units, then clamp to Q1.15.
  function automatic logic [15:0] settle_q15(longint acc, inout bit clip);
    longint q;
    q = (acc + 16384) >>> 15;
    if (q > 32767) begin
      clip = 1'b1;
      q = 32767;
    end
    if (q < -32768) begin
      clip = 1'b1;
      q = -32768;
    end
    return q[15:0];
  endfunction

  function automatic out_item_t gate_product(in_item_t beat);
    int unsigned idx;
    int          sn;
    int          cs;
    int          c00r, c00i, c01r, c01i, c10r, c10i, c11r, c11i;
    longint      a0r, a0i, a1r, a1i;
    bit          clip;
    out_item_t   res;
    a0r = beat.amp0_re;
    a0i = beat.amp0_im;
    a1r = beat.amp1_re;
    a1i = beat.amp1_im;
    // The half angle sits on a 2^17 grid, so the angle field indexes it directly.
    idx = (int'(beat.angle[14:0]) * SINE_TABLE_DEPTH) >> 15;
    if (!beat.angle[15]) begin
      sn = quarter_sine(idx);
      cs = quarter_sine(SINE_TABLE_DEPTH - idx);
    end else begin
      sn = quarter_sine(SINE_TABLE_DEPTH - idx);
      cs = -quarter_sine(idx);
    end
    c00r = UNIT_Q15; c00i = 0; c01r = 0; c01i = 0;
    c10r = 0; c10i = 0; c11r = UNIT_Q15; c11i = 0;
    case (beat.kind)
      GATE_H: begin
        c00r = HALF_ROOT2; c01r = HALF_ROOT2; c10r = HALF_ROOT2; c11r = -HALF_ROOT2;
      end
      GATE_X: begin
        c00r = 0; c11r = 0; c01r = UNIT_Q15; c10r = UNIT_Q15;
      end
      GATE_Y: begin
        c00r = 0; c11r = 0; c01i = -UNIT_Q15; c10i = UNIT_Q15;
      end
      GATE_Z:    c11r = -UNIT_Q15;
      GATE_S:    begin c11r = 0; c11i = UNIT_Q15; end
      GATE_T:    begin c11r = HALF_ROOT2; c11i = HALF_ROOT2; end
      GATE_SDAG: begin c11r = 0; c11i = -UNIT_Q15; end
      GATE_TDAG: begin c11r = HALF_ROOT2; c11i = -HALF_ROOT2; end
      GATE_RX: begin
        c00r = cs; c11r = cs; c01i = -sn; c10i = -sn;
      end
      GATE_RY: begin
        c00r = cs; c11r = cs; c01r = -sn; c10r = sn;
      end
      GATE_RZ: begin
        c00r = cs; c00i = -sn; c11r = cs; c11i = sn;
      end
      default: ;
    endcase
    clip = 1'b0;
    res.new0_re = settle_q15(c00r * a0r - c00i * a0i + c01r * a1r - c01i * a1i, clip);
    res.new0_im = settle_q15(c00r * a0i + c00i * a0r + c01r * a1i + c01i * a1r, clip);
    res.new1_re = settle_q15(c10r * a0r - c10i * a0i + c11r * a1r - c11i * a1i, clip);
    res.new1_im = settle_q15(c10r * a0i + c10i * a0r + c11r * a1i + c11i * a1r, clip);
    res.clipped = clip;
    return res;
  endfunction

  task automatic queue_beat(logic [3:0] kind, logic [15:0] angle, logic [15:0] a0r,
                            logic [15:0] a0i, logic [15:0] a1r, logic [15:0] a1i,
                            bit drain);
    queued_beat_t qb;
    qb.beat.kind    = kind;
    qb.beat.angle   = angle;
    qb.beat.amp0_re = a0r;
    qb.beat.amp0_im = a0i;
    qb.beat.amp1_re = a1r;
    qb.beat.amp1_im = a1i;
    qb.drain        = drain;
    gate_beats.push_back(qb);
  endtask

  function automatic logic [15:0] pick_amp(int style);
    case (style)
      0:       return 16'($urandom);
      1:       case ($urandom_range(0, 3))
                 0:       return 16'h8000;
                 1:       return 16'h7FFF;
                 2:       return 16'h0000;
                 default: return 16'hFFFF;
               endcase
      default: return 16'($urandom_range(0, 46340) - 23170);
    endcase
  endfunction

  function automatic logic [15:0] pick_angle();
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 4))
        0:       return 16'h0000;
        1:       return 16'h7FFF;
        2:       return 16'h8000;
        3:       return 16'h4000;
        default: return 16'hFFFF;
      endcase
    end
    return 16'($urandom);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("cycle %0d: %s is %0d, predicted %0d", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  // Driver: a new beat is presented only after the previous one was taken.
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (send_gap != 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (gate_beats.size() == 0) begin
        in_valid <= 1'b0;
      end else if (gate_beats[0].drain && amps_due.size() != 0) begin
        in_valid <= 1'b0;
      end else begin
        in_data  <= gate_beats[0].beat;
        in_valid <= 1'b1;
        void'(gate_beats.pop_front());
        if (gate_beats.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(1, 13);
        end
      end
    end
  end

  // Result sink with random stall bursts, none in the tail of the run.
  always @(negedge clk) begin
    if (sink_stall != 0) begin
      sink_stall--;
      out_ready <= 1'b0;
    end else if (gate_beats.size() > CALM_TAIL && $urandom_range(0, 9) == 0) begin
      sink_stall = $urandom_range(0, 12);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : monitor
    out_item_t want;
    cycle_count++;
    in_taken <= rst_n && in_valid && in_ready;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (amps_due.size() == 0) begin
          report_mismatch("unexpected result beat", 1, 0);
        end else begin
          want = amps_due.pop_front();
          if (out_data.new0_re !== want.new0_re)
            report_mismatch("new0_re", out_data.new0_re, want.new0_re);
          if (out_data.new0_im !== want.new0_im)
            report_mismatch("new0_im", out_data.new0_im, want.new0_im);
          if (out_data.new1_re !== want.new1_re)
            report_mismatch("new1_re", out_data.new1_re, want.new1_re);
          if (out_data.new1_im !== want.new1_im)
            report_mismatch("new1_im", out_data.new1_im, want.new1_im);
          if (out_data.clipped !== want.clipped)
            report_mismatch("clipped", out_data.clipped, want.clipped);
        end
      end
      if (in_valid && in_ready) begin
        amps_due.push_back(gate_product(in_data));
      end
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int style;
    // Directed beats: saturation, negation of -1.0, angle quadrant edges,
    // ignored angle on fixed gates and the unused gate codes.
    queue_beat(GATE_H,    16'h0000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0);
    queue_beat(GATE_H,    16'hFFFF, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0);
    queue_beat(GATE_X,    16'h1234, 16'h8000, 16'h7FFF, 16'h3039, 16'hFFFF, 1'b0);
    queue_beat(GATE_Y,    16'h0000, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 1'b0);
    queue_beat(GATE_Z,    16'hFFFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000, 1'b0);
    queue_beat(GATE_I,    16'hFFFF, 16'h8000, 16'h7FFF, 16'h0001, 16'hFFFF, 1'b0);
    queue_beat(GATE_S,    16'h5555, 16'h4000, 16'hC000, 16'h8000, 16'h0005, 1'b0);
    queue_beat(GATE_T,    16'h0000, 16'h0000, 16'h0001, 16'h7FFF, 16'h7FFF, 1'b0);
    queue_beat(GATE_SDAG, 16'hAAAA, 16'h7FFF, 16'h0000, 16'h0005, 16'h8000, 1'b0);
    queue_beat(GATE_TDAG, 16'h0000, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 1'b0);
    queue_beat(GATE_RX,   16'h0000, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 1'b0);
    queue_beat(GATE_RX,   16'h4000, 16'h5A82, 16'h0000, 16'h0000, 16'h5A82, 1'b0);
    queue_beat(GATE_RX,   16'h2000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0);
    queue_beat(GATE_RY,   16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0);
    queue_beat(GATE_RY,   16'h8000, 16'h8000, 16'h1000, 16'h7FFF, 16'hF000, 1'b0);
    queue_beat(GATE_RZ,   16'hFFFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 1'b0);
    queue_beat(GATE_RZ,   16'hC000, 16'h2000, 16'hE000, 16'h8000, 16'h7FFF, 1'b0);
    queue_beat(GATE_RZ,   16'h8001, 16'h0000, 16'h8000, 16'h0000, 16'h7FFF, 1'b0);
    for (int k = 12; k <= 15; k++) begin
      queue_beat(4'(k), 16'($urandom), 16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000, 1'b0);
    end
    for (int i = 0; i < 600; i++) begin
      style = $urandom_range(0, 2);
      queue_beat(($urandom_range(0, 15) == 0) ? 4'($urandom_range(12, 15))
                                              : 4'($urandom_range(0, 11)),
                 pick_angle(), pick_amp(style), pick_amp(style), pick_amp(style),
                 pick_amp(style), i == 0 || i == 300);
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (gate_beats.size() != 0 || in_valid) @(posedge clk);
    while (amps_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
